// ----- rtl/vertex_projection_macros.svh -----
// Assertion macros for the vertex_projection checker.
// Needs aclk and aresetn in the scope that uses them.
`ifndef VERTEX_PROJECTION_MACROS_SVH
`define VERTEX_PROJECTION_MACROS_SVH

// Check while out of reset
`define VP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check at every edge, reset included
`define VP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/vp_pkg.sv -----
// Shared types, constants and arithmetic helpers of the vertex projection block.
// No dependencies.
package vp_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int NUM_REGS   = 8;
    localparam int CW         = 59;   // clip component, signed Q.32
    localparam int AW         = 57;   // magnitude of a clip component
    localparam int RW         = 73;   // divide remainder, magnitude << 16
    localparam int QW         = 32;   // quotient bits kept
    localparam int DIV_STAGES = QW;
    localparam int BK_STAGES  = DIV_STAGES + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [2:0] {
        REG_ROW0_01 = 3'd0,
        REG_ROW0_23 = 3'd1,
        REG_ROW1_01 = 3'd2,
        REG_ROW1_23 = 3'd3,
        REG_ROW2_01 = 3'd4,
        REG_ROW2_23 = 3'd5,
        REG_ROW3_01 = 3'd6,
        REG_ROW3_23 = 3'd7
    } reg_idx_t;

    typedef logic signed [23:0] coef_t;
    typedef coef_t [3:0][3:0] mat_t;   // [row][col]

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cw;
        logic                 ortho;
    } item_t;

    typedef struct packed {
        logic          valid;
        logic          ortho;
        logic          wzero;
        logic          neg_x;
        logic          neg_y;
        logic          ovf_x;
        logic          ovf_y;
        logic [AW-1:0] d;
        logic [RW-1:0] rx;
        logic [RW-1:0] ry;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
        logic [31:0]   ox;
        logic [31:0]   oy;
        logic [31:0]   dep;
        logic          clip_ox;
        logic          clip_oy;
        logic          clip_d;
    } bk_t;

    // floor(-c / 2^16) saturated; returns {clip, value}
    function automatic logic [32:0] neg_floor_sat(input logic signed [CW-1:0] c);
        logic signed [CW-1:0]    n;
        logic signed [CW-17:0]   s;
        logic [32:0]             res;
        n = -c;
        s = CW'(n >>> 16) > 0 ? n[CW-1:16] : n[CW-1:16];
        if (s[CW-17:31] == {(CW-47){s[31]}}) begin
            res = {1'b0, s[31:0]};
        end else if (s[CW-17]) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b1, 32'h7FFF_FFFF};
        end
        return res;
    endfunction

    // one restoring step at quotient bit k; returns {bit, remainder}
    function automatic logic [RW:0] div_step(input logic [RW-1:0] r,
                                             input logic [AW-1:0] d,
                                             input int            k);
        logic [RW+QW-1:0] rr;
        logic [RW+QW-1:0] dd;
        logic [RW:0]      res;
        rr = {{QW{1'b0}}, r};
        dd = {{(RW+QW-AW){1'b0}}, d} << k;
        if (rr >= dd) begin
            res = {1'b1, RW'(rr - dd)};
        end else begin
            res = {1'b0, r};
        end
        return res;
    endfunction

    // apply sign and saturate a quotient magnitude; returns {clip, value}
    function automatic logic [32:0] div_sat(input logic [QW-1:0] q,
                                            input logic          ovf,
                                            input logic          neg);
        logic        big;
        logic [32:0] res;
        big = ovf || (neg ? (q[31] && (|q[30:0])) : q[31]);
        if (big) begin
            res = {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end else begin
            res = {1'b0, neg ? 32'(-q) : q};
        end
        return res;
    endfunction

endpackage

// ----- rtl/vertex_projection.sv -----
// Channel  | handshake            | payload
// s_       | s_tvalid / s_tready  | s_tdata: vertex_x, vertex_y, vertex_z
// m_       | m_tvalid / m_tready  | m_tdata: screen_x, screen_y, view_depth; m_tuser
// cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data
// One vertex per cycle while m_ does not stall; a vertex passes 3 front stages, the queue,
// 34 back stages (one quotient bit per divide stage) and the output register.
// Reset is synchronous, active low, and leaves the identity matrix in perspective mode.
// A stall on m_ halts the back end; the queue then fills and halts the front end.
// cfg_ready is always high.
// Top level: configuration registers, front end, queue and back end.
// Depends on vp_pkg, vp_front, vp_fifo, vp_back.
module vertex_projection (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [95:0]                    s_tdata,   // vertex_x, vertex_y, vertex_z
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [95:0]                    m_tdata,   // screen_x, screen_y, view_depth
    output logic [1:0]                     m_tuser,   // w_zero, clipped
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [48:0]                    cfg_data
);
    import vp_pkg::*;

    logic [47:0] regs_reg [NUM_REGS];
    logic        ortho_reg;
    mat_t        mat;
    logic        push_valid, push_ready, pop_valid, pop_ready;
    item_t       push_item, pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[REG_ROW0_01] <= 48'd65536;
            regs_reg[REG_ROW0_23] <= '0;
            regs_reg[REG_ROW1_01] <= 48'd1099511627776;
            regs_reg[REG_ROW1_23] <= '0;
            regs_reg[REG_ROW2_01] <= '0;
            regs_reg[REG_ROW2_23] <= 48'd65536;
            regs_reg[REG_ROW3_01] <= '0;
            regs_reg[REG_ROW3_23] <= 48'd1099511627776;
            ortho_reg             <= 1'b0;
        end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
            regs_reg[cfg_index[2:0]] <= cfg_data[47:0];
            if (reg_idx_t'(cfg_index[2:0]) == REG_ROW3_23) begin
                ortho_reg <= cfg_data[48];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            mat[r][0] = regs_reg[2*r][23:0];
            mat[r][1] = regs_reg[2*r][47:24];
            mat[r][2] = regs_reg[2*r+1][23:0];
            mat[r][3] = regs_reg[2*r+1][47:24];
        end
    end

    vp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .mat        (mat),
        .ortho      (ortho_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    vp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    vp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- rtl/vp_front.sv -----
// Front end: accepts vertices and forms clip components cx, cy, cw.
// Depends on vp_pkg. Three register stages, pushes into the queue.
module vp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // vertex_x, vertex_y, vertex_z
    input  vp_pkg::mat_t         mat,
    input  logic                 ortho,
    output logic                 push_valid,
    input  logic                 push_ready,
    output vp_pkg::item_t        push_item
);
    import vp_pkg::*;

    logic                 en;
    logic signed [31:0]   vin [3];
    logic signed [55:0]   p_reg [3][3];
    logic signed [57:0]   a_reg [3];
    logic signed [57:0]   b_reg [3];
    logic signed [CW-1:0] c_reg [3];
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 o1_reg, o2_reg, o3_reg;

    // lane 2 carries matrix column 3 (w); z is not needed
    function automatic int col_of(input int l);
        return (l == 2) ? 3 : l;
    endfunction

    assign en       = !v3_reg || push_ready;
    assign s_tready = en;
    assign vin[0]   = s_tdata[31:0];
    assign vin[1]   = s_tdata[63:32];
    assign vin[2]   = s_tdata[95:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o1_reg <= ortho;
            o2_reg <= o1_reg;
            o3_reg <= o2_reg;
            for (int r = 0; r < 3; r++) begin
                for (int l = 0; l < 3; l++) begin
                    p_reg[r][l] <= vin[r] * mat[r][col_of(l)];
                end
            end
            for (int l = 0; l < 3; l++) begin
                a_reg[l] <= 58'(p_reg[0][l]) + 58'(p_reg[1][l]);
                b_reg[l] <= 58'(p_reg[2][l]) + 58'($signed({mat[3][col_of(l)], 32'h0}));
                c_reg[l] <= CW'(a_reg[l]) + CW'(b_reg[l]);
            end
        end
    end

    assign push_valid      = v3_reg;
    assign push_item.cx    = c_reg[0];
    assign push_item.cy    = c_reg[1];
    assign push_item.cw    = c_reg[2];
    assign push_item.ortho = o3_reg;

endmodule

// ----- rtl/vp_fifo.sv -----
// Short queue between front and back ends.
// Depends on vp_pkg.
module vp_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  vp_pkg::item_t  push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output vp_pkg::item_t  pop_item
);
    import vp_pkg::*;

    item_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/vp_back.sv -----
// Back end: perspective divide pipeline, orthographic path and output register.
// Depends on vp_pkg. One quotient bit per divide stage for both x and y.
module vp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  vp_pkg::item_t  pop_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [95:0]    m_tdata,   // screen_x, screen_y, view_depth
    output logic [1:0]     m_tuser    // w_zero, clipped
);
    import vp_pkg::*;

    logic        en;
    bk_t         st_reg  [BK_STAGES];
    bk_t         st_next [BK_STAGES];
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    assign en        = !m_tvalid_reg || m_tready;
    assign pop_ready = en;

    always_comb begin
        logic [AW-1:0] ax, ay;
        logic [32:0]   sx, sy, sd;
        logic [RW:0]   tx, ty;
        bk_t           s;
        // entry: magnitudes, signs and the orthographic / depth values
        ax = pop_item.cx[CW-1] ? AW'(-pop_item.cx) : AW'(pop_item.cx);
        ay = pop_item.cy[CW-1] ? AW'(-pop_item.cy) : AW'(pop_item.cy);
        sx = neg_floor_sat(pop_item.cx);
        sy = neg_floor_sat(pop_item.cy);
        sd = neg_floor_sat(pop_item.cw);
        s         = '0;
        s.valid   = pop_valid;
        s.ortho   = pop_item.ortho;
        s.wzero   = (pop_item.cw == '0);
        s.neg_x   = pop_item.cx[CW-1] ^ pop_item.cw[CW-1];
        s.neg_y   = pop_item.cy[CW-1] ^ pop_item.cw[CW-1];
        s.d       = pop_item.cw[CW-1] ? AW'(-pop_item.cw) : AW'(pop_item.cw);
        s.rx      = {ax, 16'h0};
        s.ry      = {ay, 16'h0};
        s.ox      = sx[31:0];
        s.oy      = sy[31:0];
        s.dep     = sd[31:0];
        s.clip_ox = sx[32];
        s.clip_oy = sy[32];
        s.clip_d  = sd[32];
        st_next[0] = s;

        // quotient at or above 2^32 cannot fit: flag it up front
        s = st_reg[0];
        s.ovf_x = {16'h0, s.rx[RW-1:16]} >= {s.d, 16'h0};
        s.ovf_y = {16'h0, s.ry[RW-1:16]} >= {s.d, 16'h0};
        st_next[1] = s;

        for (int i = 0; i < DIV_STAGES; i++) begin
            s  = st_reg[i+1];
            tx = div_step(s.rx, s.d, DIV_STAGES - 1 - i);
            ty = div_step(s.ry, s.d, DIV_STAGES - 1 - i);
            s.rx = tx[RW-1:0];
            s.ry = ty[RW-1:0];
            s.qx = {s.qx[QW-2:0], tx[RW]};
            s.qy = {s.qy[QW-2:0], ty[RW]};
            st_next[i+2] = s;
        end
    end

    always_comb begin
        bk_t         f;
        logic [32:0] dx, dy;
        f  = st_reg[BK_STAGES-1];
        dx = div_sat(f.qx, f.ovf_x, f.neg_x);
        dy = div_sat(f.qy, f.ovf_y, f.neg_y);
        priority if (f.ortho) begin
            m_tdata_next = {f.dep, f.oy, f.ox};
            m_tuser_next = {f.clip_ox | f.clip_oy | f.clip_d, 1'b0};
        end else if (f.wzero) begin
            m_tdata_next = '0;
            m_tuser_next = 2'b01;
        end else begin
            m_tdata_next = {f.dep, dy[31:0], dx[31:0]};
            m_tuser_next = {dx[32] | dy[32] | f.clip_d, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BK_STAGES; i++) begin
                st_reg[i].valid <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            st_reg       <= st_next;
            m_tvalid_reg <= st_reg[BK_STAGES-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/vp_checker.sv -----
// Port-level checker for vertex_projection, bound to the top level.
// Depends on vertex_projection_macros.svh.
`include "vertex_projection_macros.svh"

module vp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);
    // no word may survive reset
    `VP_ASSERT_ALWAYS(a_rst_empty, !aresetn |=> !m_tvalid, "result word after reset")
    // a zero-w word carries zeros and is never saturated
    `VP_ASSERT(a_wzero_clean, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]), "w_zero word not clean")
    // hold a stalled word
    `VP_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled word changed")
endmodule

bind vertex_projection vp_checker u_vp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
